// ===== src/tea_pkg.sv =====
// Package for the TEA block cipher core: key and pipeline types, cipher constants,
// and the round mixing function. No dependencies.
package tea_pkg;

  localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

  // Command key used after reset
  localparam logic [31:0] KEY0_RESET = 32'hB0F6_FE55;
  localparam logic [31:0] KEY1_RESET = 32'h410B_BF62;
  localparam logic [31:0] KEY2_RESET = 32'hB47C_B3C9;
  localparam logic [31:0] KEY3_RESET = 32'h7B29_3E97;

  localparam int unsigned CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2,
    REG_KEY3 = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } key_t;

  // Data that travels down the row of cells
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] y;
    logic [31:0] z;
  } stage_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] v, input logic [31:0] s,
                                          input logic [31:0] ka, input logic [31:0] kb);
    tea_mix = ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

endpackage

// ===== src/tea_if.sv =====
// Handshake channel interfaces for the TEA core: block requests in, results out.
// Stand-alone, no package needed.
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] block_first;
  logic [31:0] block_second;

  modport source(output valid, output cmd, output block_first, output block_second,
                 input ready);
  modport sink(input valid, input cmd, input block_first, input block_second,
               output ready);
endinterface

interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_first;
  logic [31:0] result_second;

  modport source(output valid, output result_first, output result_second, input ready);
  modport sink(input valid, input result_first, input result_second, output ready);
endinterface

// ===== src/tea_cfg_regs.sv =====
// APB-style key register file for the TEA core.
// Depends on tea_pkg.
module tea_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tea_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output tea_pkg::key_t                    key
);

  tea_pkg::key_t     key_r;
  tea_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = tea_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign key    = key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r.k0 <= tea_pkg::KEY0_RESET;
      key_r.k1 <= tea_pkg::KEY1_RESET;
      key_r.k2 <= tea_pkg::KEY2_RESET;
      key_r.k3 <= tea_pkg::KEY3_RESET;
    end else if (wr_en) begin
      unique case (idx)
        tea_pkg::REG_KEY0: key_r.k0 <= pwdata;
        tea_pkg::REG_KEY1: key_r.k1 <= pwdata;
        tea_pkg::REG_KEY2: key_r.k2 <= pwdata;
        tea_pkg::REG_KEY3: key_r.k3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tea_pkg::REG_KEY0: prdata = key_r.k0;
      tea_pkg::REG_KEY1: prdata = key_r.k1;
      tea_pkg::REG_KEY2: prdata = key_r.k2;
      tea_pkg::REG_KEY3: prdata = key_r.k3;
      default:           prdata = key_r.k0;
    endcase
  end

endmodule

// ===== src/tea_cell.sv =====
// One half-round of TEA with its stage register; a row of these forms the cipher.
// Depends on tea_pkg.
module tea_cell #(
  parameter logic [31:0] ENC_SUM = 32'h9E37_79B9,
  parameter logic [31:0] DEC_SUM = 32'hC6EF_3720,
  parameter bit          HALF    = 1'b0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  tea_pkg::stage_t in_data,
  input  tea_pkg::key_t   key,
  output logic            out_valid,
  output tea_pkg::stage_t out_data
);

  logic            valid_r;
  tea_pkg::stage_t data_r;
  tea_pkg::stage_t data_nxt;
  logic            dec;
  logic            upd_y;
  logic [31:0]     sum;
  logic [31:0]     src;
  logic [31:0]     dst;
  logic [31:0]     ka;
  logic [31:0]     kb;
  logic [31:0]     mix;
  logic [31:0]     res;

  // Encrypt: first half updates y, second z. Decrypt runs the halves swapped.
  assign dec   = (in_data.cmd == tea_pkg::CMD_DECRYPT);
  assign upd_y = (dec == HALF);
  assign sum   = dec ? DEC_SUM : ENC_SUM;
  assign src   = upd_y ? in_data.z : in_data.y;
  assign dst   = upd_y ? in_data.y : in_data.z;
  assign ka    = upd_y ? key.k0 : key.k2;
  assign kb    = upd_y ? key.k1 : key.k3;
  assign mix   = tea_pkg::tea_mix(src, sum, ka, kb);
  assign res   = dec ? (dst - mix) : (dst + mix);

  always_comb begin
    data_nxt = in_data;
    if (upd_y) begin
      data_nxt.y = res;
    end else begin
      data_nxt.z = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/tea_block_cipher_core.sv =====
// TEA block cipher core: top level with the chain of half-round cells.
// Depends on tea_pkg, tea_if.sv, tea_cfg_regs and tea_cell.
//
// Usage:
//   in_ch  : block requests (cmd 0 encrypt / 1 decrypt, block_first, block_second),
//            taken when valid and ready are both high.
//   out_ch : result_first / result_second, one result per request, in order.
//   APB    : four 32-bit key words at byte addresses 0x0, 0x4, 0x8, 0xC
//            (paddr[3:2] picks the word). pready is tied high; reads return the key.
//   The user must rewrite keys only while no request is in flight; the core does not enforce it.
// Pipeline: one cell register per half-round; the last cell is the output register.
// Throughput: one request per cycle when not stalled. The whole row advances together
//   whenever the output register is empty or being taken.
// Stall: when out_ch.ready is low with a result waiting, every cell holds and
//   in_ch.ready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous): all cell valid bits clear, key words return to
//   the built-in command key.
module tea_block_cipher_core #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tea_in_if.sink                          in_ch,
  tea_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tea_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned CELLS = 2 * ROUND_COUNT;

  tea_pkg::key_t   key;
  logic            advance;
  logic            vld  [CELLS+1];
  tea_pkg::stage_t data [CELLS+1];

  tea_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key     (key)
  );

  // Global advance: the row moves when the output slot is free or drained
  assign advance     = !vld[CELLS] || out_ch.ready;
  assign in_ch.ready = advance;

  assign vld[0]      = in_ch.valid;
  assign data[0].cmd = tea_pkg::cmd_t'(in_ch.cmd);
  assign data[0].y   = in_ch.block_first;
  assign data[0].z   = in_ch.block_second;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    // Round number of this cell and the running sum it sees in each mode
    localparam longint unsigned RND     = longint'(i / 2);
    localparam longint unsigned ENC_MUL = longint'(tea_pkg::TEA_DELTA) * (RND + 64'd1);
    localparam longint unsigned DEC_MUL = longint'(tea_pkg::TEA_DELTA)
                                          * (longint'(ROUND_COUNT) - RND);
    localparam logic [31:0]     ENC_S   = ENC_MUL[31:0];
    localparam logic [31:0]     DEC_S   = DEC_MUL[31:0];

    tea_cell #(
      .ENC_SUM (ENC_S),
      .DEC_SUM (DEC_S),
      .HALF    (bit'(i % 2))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (advance),
      .in_valid  (vld[i]),
      .in_data   (data[i]),
      .key       (key),
      .out_valid (vld[i+1]),
      .out_data  (data[i+1])
    );
  end

  assign out_ch.valid         = vld[CELLS];
  assign out_ch.result_first  = data[CELLS].y;
  assign out_ch.result_second = data[CELLS].z;

endmodule

// ===== test/tea_cipher_checker.sv =====
// Checker for the TEA block cipher core: watches the request, result and APB ports,
// predicts every result from its own copy of the key and compares it in order.
// Depends on tea_pkg.
module tea_cipher_checker #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_cmd,
  input  logic [31:0]                    in_block_first,
  input  logic [31:0]                    in_block_second,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [31:0]                    out_result_first,
  input  logic [31:0]                    out_result_second,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [tea_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic [31:0]                    prdata,
  output int                             fail_count,
  output int                             pending_blocks
);

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } cipher_block_t;

  localparam logic [31:0] DECRYPT_SUM_START = tea_pkg::TEA_DELTA * ROUND_COUNT;

  tea_pkg::key_t key_copy;
  cipher_block_t expected_blocks[$];

  initial begin
    fail_count     = 0;
    pending_blocks = 0;
  end

  function automatic logic [31:0] round_mix(logic [31:0] v, logic [31:0] s,
                                            logic [31:0] ka, logic [31:0] kb);
    return ((v << 4) + ka) ^ (v + s) ^ ((v >> 5) + kb);
  endfunction

  function automatic cipher_block_t tea_cipher_predict(tea_pkg::cmd_t op, logic [31:0] a,
                                                      logic [31:0] b, tea_pkg::key_t k);
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sum;
    y = a;
    z = b;
    if (op == tea_pkg::CMD_DECRYPT) begin
      // undo the rounds, last first
      sum = DECRYPT_SUM_START;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        z -= round_mix(y, sum, k.k2, k.k3);
        y -= round_mix(z, sum, k.k0, k.k1);
        sum -= tea_pkg::TEA_DELTA;
      end
    end else begin
      sum = '0;
      for (int r = 0; r < ROUND_COUNT; r++) begin
        sum += tea_pkg::TEA_DELTA;
        y += round_mix(z, sum, k.k0, k.k1);
        z += round_mix(y, sum, k.k2, k.k3);
      end
    end
    return '{first: y, second: z};
  endfunction

  function automatic void check_word(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cipher_block_t want;
    logic [31:0]   key_word;
    if (!rst_n) begin
      key_copy = '{k0: tea_pkg::KEY0_RESET, k1: tea_pkg::KEY1_RESET,
                   k2: tea_pkg::KEY2_RESET, k3: tea_pkg::KEY3_RESET};
      expected_blocks.delete();
    end else begin
      if (psel && penable && pready) begin
        case (tea_pkg::reg_idx_t'(paddr[3:2]))
          tea_pkg::REG_KEY0: key_word = key_copy.k0;
          tea_pkg::REG_KEY1: key_word = key_copy.k1;
          tea_pkg::REG_KEY2: key_word = key_copy.k2;
          default:           key_word = key_copy.k3;
        endcase
        if (pwrite) begin
          case (tea_pkg::reg_idx_t'(paddr[3:2]))
            tea_pkg::REG_KEY0: key_copy.k0 = pwdata;
            tea_pkg::REG_KEY1: key_copy.k1 = pwdata;
            tea_pkg::REG_KEY2: key_copy.k2 = pwdata;
            default:           key_copy.k3 = pwdata;
          endcase
        end else begin
          check_word("key readback", key_word, prdata);
        end
      end
      if (in_valid && in_ready)
        expected_blocks.insert(expected_blocks.size(),
                               tea_cipher_predict(tea_pkg::cmd_t'(in_cmd), in_block_first,
                                                  in_block_second, key_copy));
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h %h", $time,
                   out_result_first, out_result_second);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          check_word("result_first", want.first, out_result_first);
          check_word("result_second", want.second, out_result_second);
        end
      end
    end
    pending_blocks <= expected_blocks.size();
  end

endmodule

// ===== test/tea_block_cipher_core_tb.sv =====
// Top of the TEA core testbench: clock, reset, request and key stimulus, result
// back-pressure, watchdog and verdict. Depends on tea_pkg, tea_if.sv,
// tea_block_cipher_core and tea_cipher_checker.
module tea_block_cipher_core_tb;

  localparam int unsigned ROUND_COUNT    = 32;
  // request to result is one register per half-round
  localparam int unsigned LATENCY        = 2 * ROUND_COUNT;
  localparam int          PHASE_REQUESTS = 248;
  localparam int          HOLD_CYCLES    = 400;
  // longest legal quiet stretch is the long result hold-off; keep well above it
  localparam int          WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [tea_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending_blocks;

  // idling controls for the request driver and the result receiver, and the watchdog count
  bit tx_idle_en;
  bit rx_idle_en;
  int rx_hold_left;
  int rx_stall_left;
  int quiet_cycles;

  tea_pkg::key_t key_plan[7];

  tea_in_if  in_ch();
  tea_out_if out_ch();

  tea_block_cipher_core #(
    .ROUND_COUNT(ROUND_COUNT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  tea_cipher_checker #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_cmd           (in_ch.cmd),
    .in_block_first   (in_ch.block_first),
    .in_block_second  (in_ch.block_second),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result_first (out_ch.result_first),
    .out_result_second(out_ch.result_second),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .fail_count       (fail_count),
    .pending_blocks   (pending_blocks)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: long hold-off has priority, then random stall bursts,
  // otherwise ready. Driven on the falling edge only.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_stall_left = $urandom_range(1, 11) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: anything moving on any port resets the count.
  always @(posedge clk) begin
    if (!rst_n ||
        (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, nothing moved for %0d cycles", $time,
                 quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // One block request. A random gap (valid low) may come first; valid then
  // stays high until the request is taken, and is left high for the next one.
  task automatic send_block(tea_pkg::cmd_t op, logic [31:0] first, logic [31:0] second);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= op;
    in_ch.block_first  <= first;
    in_ch.block_second <= second;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering requests and wait until every result is back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_blocks != 0) @(negedge clk);
  endtask

  // APB setup then access; pready is waited on although the core ties it high.
  task automatic key_access(bit is_write, tea_pkg::reg_idx_t idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= tea_pkg::CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_key(tea_pkg::key_t k);
    key_access(1'b1, tea_pkg::REG_KEY0, k.k0);
    key_access(1'b1, tea_pkg::REG_KEY1, k.k1);
    key_access(1'b1, tea_pkg::REG_KEY2, k.k2);
    key_access(1'b1, tea_pkg::REG_KEY3, k.k3);
    for (int i = 0; i < 4; i++) key_access(1'b0, tea_pkg::reg_idx_t'(i), '0);
  endtask

  // Half full random words, half corner patterns.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Random requests; idling on each side is re-chosen every 50 requests so
  // some stretches run without any gaps. The final part leaves the idling as set.
  task automatic send_random_blocks(int count, bit final_part);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0 && !final_part) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_block($urandom_range(0, 1) ? tea_pkg::CMD_DECRYPT : tea_pkg::CMD_ENCRYPT,
                 pick_word(), pick_word());
    end
  endtask

  initial begin
    // known values on every input from time zero
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = tea_pkg::CMD_ENCRYPT;
    in_ch.block_first  = '0;
    in_ch.block_second = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    tx_idle_en         = 1'b1;
    rx_idle_en         = 1'b1;
    rx_hold_left       = 0;
    rx_stall_left      = 0;

    // key schedule: reset key, all zeros, all ones, alternating and single-bit patterns, then random
    key_plan[0] = '{k0: tea_pkg::KEY0_RESET, k1: tea_pkg::KEY1_RESET,
                    k2: tea_pkg::KEY2_RESET, k3: tea_pkg::KEY3_RESET};
    key_plan[1] = '0;
    key_plan[2] = '1;
    key_plan[3] = '{k0: 32'hAAAA_AAAA, k1: 32'h5555_5555, k2: 32'h0000_0001,
                    k3: 32'h8000_0000};
    for (int p = 4; p < 7; p++)
      key_plan[p] = '{k0: $urandom, k1: $urandom, k2: $urandom, k3: $urandom};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // key words must read back as the built-in command key after reset
    for (int i = 0; i < 4; i++) key_access(1'b0, tea_pkg::reg_idx_t'(i), '0);

    // directed: both operations on the extreme and patterned blocks
    send_block(tea_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(tea_pkg::CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(tea_pkg::CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(tea_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(tea_pkg::CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(tea_pkg::CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(tea_pkg::CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    send_block(tea_pkg::CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    send_block(tea_pkg::CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(tea_pkg::CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(tea_pkg::CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    send_block(tea_pkg::CMD_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567);

    send_random_blocks(PHASE_REQUESTS, 1'b0);

    for (int p = 1; p < 7; p++) begin
      // the sender waits out every result before the key changes
      drain_results();
      load_key(key_plan[p]);
      if (p == 2) begin
        // long result hold-off while requests keep coming back to back:
        // the row fills and in_ch.ready has to drop
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        rx_hold_left = HOLD_CYCLES;
        send_random_blocks(150, 1'b1);
        send_random_blocks(PHASE_REQUESTS - 150, 1'b0);
      end else if (p == 6) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random_blocks(PHASE_REQUESTS, 1'b1);
      end else begin
        send_random_blocks(PHASE_REQUESTS, 1'b0);
      end
    end

    drain_results();
    // catch any stray result the core might still push out
    repeat (LATENCY + 16) @(negedge clk);

    if (fail_count == 0 && pending_blocks == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tea_pkg.sv
src/tea_if.sv
src/tea_cfg_regs.sv
src/tea_cell.sv
src/tea_block_cipher_core.sv
test/tea_cipher_checker.sv
test/tea_block_cipher_core_tb.sv
